[rtl/core/adhc_pkg.sv]
// shared constants and helpers for the ascii decimal/hex converter
`timescale 1ns / 1ps

package adhc_pkg;

  // default accumulator width
  localparam int VALUE_BITS_DEFAULT = 32;

  // answer queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // ascii codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPF   = 8'h46;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // offsets from digit value to character
  localparam logic [7:0] DEC_CHAR_OFS = 8'd48;
  localparam logic [7:0] HEX_CHAR_OFS = 8'd55;

  // digit value to its uppercase character
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] dw;
    dw = {4'b0000, d};
    if (d <= 4'd9) begin
      digit_char = dw + DEC_CHAR_OFS;
    end else begin
      digit_char = dw + HEX_CHAR_OFS;
    end
  endfunction

endpackage

[rtl/core/adhc_front.sv]
// front end: parser with saturating accumulator, one job per token till a minus halts
`timescale 1ns / 1ps

module adhc_front
  import adhc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_char,
  input  logic                  q_full,
  output logic                  push,
  output logic [VALUE_BITS-1:0] push_value,
  output logic                  push_hex
);

  localparam int WIDE = VALUE_BITS + 4;

  logic [VALUE_BITS-1:0] accumulator, accumulator_next;
  logic [1:0]            token_position, token_position_next;
  logic                  hex_token, hex_token_next;
  logic                  digits_ended, digits_ended_next;
  logic                  halted, halted_next;

  logic                  accept;
  logic                  is_term, is_dec, is_uc_hex;
  logic [3:0]            digit;
  logic [WIDE-1:0]       acc_w, scaled, sum;
  logic [VALUE_BITS-1:0] acc_new;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // character classes
  assign is_term   = (in_char == CH_SPACE) || (in_char == CH_TAB) ||
                     (in_char == CH_CR) || (in_char == CH_LF);
  assign is_dec    = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
  assign is_uc_hex = (in_char >= CH_UPA) && (in_char <= CH_UPF);
  assign digit     = is_dec ? in_char[3:0] : 4'(in_char[3:0] + 4'd9);

  // saturating multiply-add, radix 16 in hex tokens and 10 otherwise
  always_comb begin
    acc_w  = WIDE'(accumulator);
    scaled = hex_token ? (acc_w << 4) : ((acc_w << 3) + (acc_w << 1));
    sum    = scaled + WIDE'(digit);
    acc_new = (|sum[WIDE-1:VALUE_BITS]) ? '1 : sum[VALUE_BITS-1:0];
  end

  // token state update
  always_comb begin
    accumulator_next    = accumulator;
    token_position_next = token_position;
    hex_token_next      = hex_token;
    digits_ended_next   = digits_ended;
    halted_next         = halted;
    push                = 1'b0;
    if (accept && !halted) begin
      if (is_term) begin
        if (token_position != 2'd0) begin
          push                = 1'b1;
          accumulator_next    = '0;
          token_position_next = 2'd0;
          hex_token_next      = 1'b0;
          digits_ended_next   = 1'b0;
        end
      end else if (token_position == 2'd0) begin
        if (in_char == CH_MINUS) begin
          halted_next       = 1'b1;
          accumulator_next  = '0;
          hex_token_next    = 1'b0;
          digits_ended_next = 1'b0;
        end else begin
          if (is_dec) begin
            accumulator_next = acc_new;
          end else begin
            digits_ended_next = 1'b1;
          end
          token_position_next = 2'd1;
        end
      end else begin
        if (token_position == 2'd1 && in_char == CH_X) begin
          hex_token_next   = 1'b1;
          accumulator_next = '0;
        end else if (hex_token) begin
          if (is_dec || is_uc_hex) begin
            accumulator_next = acc_new;
          end
        end else if (!digits_ended) begin
          if (is_dec) begin
            accumulator_next = acc_new;
          end else begin
            digits_ended_next = 1'b1;
          end
        end
        if (token_position != 2'd3) begin
          token_position_next = token_position + 2'd1;
        end
      end
    end
  end

  assign push_value = accumulator;
  assign push_hex   = hex_token;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator    <= '0;
      token_position <= 2'd0;
      hex_token      <= 1'b0;
      digits_ended   <= 1'b0;
      halted         <= 1'b0;
    end else begin
      accumulator    <= accumulator_next;
      token_position <= token_position_next;
      hex_token      <= hex_token_next;
      digits_ended   <= digits_ended_next;
      halted         <= halted_next;
    end
  end

endmodule

[rtl/core/adhc_queue.sv]
// small job queue between parser and answer generator
`timescale 1ns / 1ps

module adhc_queue
  import adhc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [VALUE_BITS-1:0] push_value,
  input  logic                  push_hex,
  output logic                  full,
  input  logic                  pop,
  output logic                  empty,
  output logic [VALUE_BITS-1:0] head_value,
  output logic                  head_hex
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  logic [VALUE_BITS-1:0] value_q [QUEUE_DEPTH];
  logic                  hex_q   [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [CNT_BITS-1:0]   count;

  assign full       = (count == CNT_BITS'(QUEUE_DEPTH));
  assign empty      = (count == '0);
  assign head_value = value_q[rd_ptr];
  assign head_hex   = hex_q[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      value_q[wr_ptr] <= push_value;
      hex_q[wr_ptr]   <= push_hex;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/core/adhc_back.sv]
// back end: converts one job into answer characters through a skid-free output register
`timescale 1ns / 1ps

module adhc_back
  import adhc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  empty,
  input  logic [VALUE_BITS-1:0] head_value,
  input  logic                  head_hex,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_char,
  output logic                  line_end
);

  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int HEX_BITS   = HEX_DIGITS * 4;
  localparam int DIG_BITS   = DEC_DIGITS * 4;
  localparam int LEFT_BITS  = $clog2(DEC_DIGITS + 1);
  localparam int CNT_BITS   = $clog2(VALUE_BITS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DABBLE = 3'd1;
  localparam logic [2:0] S_PFX0   = 3'd2;
  localparam logic [2:0] S_PFX1   = 3'd3;
  localparam logic [2:0] S_SKIP   = 3'd4;
  localparam logic [2:0] S_DIGIT  = 3'd5;
  localparam logic [2:0] S_NL     = 3'd6;

  logic [2:0]            state;
  logic [DIG_BITS-1:0]   digits, digits_adj, hex_load;
  logic [VALUE_BITS-1:0] shifter;
  logic [CNT_BITS-1:0]   cnt;
  logic [LEFT_BITS-1:0]  left;
  logic [3:0]            top_digit;
  logic                  slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign pop       = (state == S_IDLE) && !empty;
  assign top_digit = digits[DIG_BITS-1 -: 4];

  // value placed at the top of the digit register for hex answers
  always_comb begin
    hex_load = '0;
    hex_load[DIG_BITS-1 -: HEX_BITS] = HEX_BITS'(head_value);
  end

  // add-3 correction on every bcd digit
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      digits_adj[i*4 +: 4] = (digits[i*4 +: 4] >= 4'd5) ?
                             4'(digits[i*4 +: 4] + 4'd3) : digits[i*4 +: 4];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!empty) begin
            state <= head_hex ? S_DABBLE : S_PFX0;
          end
        end
        S_DABBLE: begin
          if (cnt == CNT_BITS'(1)) begin
            state <= S_SKIP;
          end
        end
        S_PFX0: begin
          if (slot_free) begin
            state <= S_PFX1;
          end
        end
        S_PFX1: begin
          if (slot_free) begin
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (!(left > LEFT_BITS'(1) && top_digit == 4'd0)) begin
            state <= S_DIGIT;
          end
        end
        S_DIGIT: begin
          if (slot_free && left == LEFT_BITS'(1)) begin
            state <= S_NL;
          end
        end
        S_NL: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // digit datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (!empty) begin
          if (head_hex) begin
            digits  <= '0;
            shifter <= head_value;
            cnt     <= CNT_BITS'(VALUE_BITS);
          end else begin
            digits <= hex_load;
            left   <= LEFT_BITS'(HEX_DIGITS);
          end
        end
      end
      S_DABBLE: begin
        digits  <= {digits_adj[DIG_BITS-2:0], shifter[VALUE_BITS-1]};
        shifter <= shifter << 1;
        cnt     <= cnt - 1'b1;
        left    <= LEFT_BITS'(DEC_DIGITS);
      end
      S_SKIP: begin
        if (left > LEFT_BITS'(1) && top_digit == 4'd0) begin
          digits <= digits << 4;
          left   <= left - 1'b1;
        end
      end
      S_DIGIT: begin
        if (slot_free) begin
          digits <= digits << 4;
          left   <= left - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= (state == S_PFX0) || (state == S_PFX1) ||
                   (state == S_DIGIT) || (state == S_NL);
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      line_end <= (state == S_NL);
      case (state)
        S_PFX0:  out_char <= CH_ZERO;
        S_PFX1:  out_char <= CH_X;
        S_NL:    out_char <= CH_LF;
        default: out_char <= digit_char(top_digit);
      endcase
    end
  end

endmodule

[rtl/core/ascii_decimal_hex_converter_core.sv]
// Flow: a terminating transfer pushes its job into the answer queue, and the answer generator
//   pops it when idle. A decimal token is answered in hex with a 0x prefix; a hex token is
//   answered in decimal after a double-dabble pass. Both skip leading zeros (up to 7 for a
//   decimal token, 9 for a hex token at default). Throughput: one input character per cycle
//   while the 2-entry answer queue has room; the next job is popped after the answer's newline.
// Reset: synchronous rst clears the token state, the halt flag, the queue and the output.
`timescale 1ns / 1ps

module ascii_decimal_hex_converter_core
  import adhc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       line_end
);

  logic                  q_full, q_empty, push, pop, push_hex, head_hex;
  logic [VALUE_BITS-1:0] push_value, head_value;

  // token parser
  adhc_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char    (in_char),
    .q_full     (q_full),
    .push       (push),
    .push_value (push_value),
    .push_hex   (push_hex)
  );

  // answer job queue
  adhc_queue #(.VALUE_BITS(VALUE_BITS)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_value (push_value),
    .push_hex   (push_hex),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head_value (head_value),
    .head_hex   (head_hex)
  );

  // answer generator
  adhc_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (q_empty),
    .head_value (head_value),
    .head_hex   (head_hex),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_char   (out_char),
    .line_end   (line_end)
  );

endmodule

[rtl/core/adhc_checker.sv]
// port-level checks for the converter core and their bind
`timescale 1ns / 1ps

module adhc_checker
  import adhc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_char,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       line_end
);

  // stalled input transfer holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_char))
    else $error("stalled input changed");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(line_end))
    else $error("stalled result changed");

  // line end marks only a newline
  a_end_is_lf: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_end |-> out_char == CH_LF)
    else $error("line_end on a non-newline character");

  // every newline closes an answer
  a_lf_is_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_char == CH_LF |-> line_end)
    else $error("newline without line_end");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ascii_decimal_hex_converter_core adhc_checker u_adhc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_char   (in_char),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_char  (out_char),
  .line_end  (line_end)
);
